>>> hw/rtl/wcrp_pkg.sv
// Shared constants for the waveform column RGB peak block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wcrp_pkg;

    // Column counter wraps after this many columns
    localparam int MaxColumns = 4096;
    localparam int ColW       = $clog2(MaxColumns);

    // Field widths
    localparam int LvlW    = 8;
    localparam int GainW   = 16;
    localparam int HalfW   = 12;
    localparam int EnergyW = 34;
    localparam int CompW   = 34;
    localparam int OffW    = 24;
    localparam int ClrW    = 13;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] RegLowGain  = 3'd0;
    localparam logic [2:0] RegMidGain  = 3'd1;
    localparam logic [2:0] RegHighGain = 3'd2;
    localparam logic [2:0] RegOverall  = 3'd3;
    localparam logic [2:0] RegHalf     = 3'd4;
    localparam logic [2:0] RegLowClr   = 3'd5;
    localparam logic [2:0] RegMidClr   = 3'd6;
    localparam logic [2:0] RegHighClr  = 3'd7;

endpackage

`default_nettype wire

>>> hw/rtl/waveform_column_rgb_peak_top.sv
// Waveform column RGB peak block: frame front end with left/right energy lanes,
// column maxima, colour and bar offset lanes, output register.
// Depends on wcrp_pkg, wcrp_energy, wcrp_root, wcrp_norm.
// Frames that do not end a column are taken one per cycle unless a column end
// is in progress. A column-ending frame stalls input until its bar is
// registered (25-step square root in the bar offset lanes), longer while a
// previous bar is held by out_stall.
// rst_n clears control, maxima, column count and loads register defaults.
`default_nettype none

module waveform_column_rgb_peak_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // frames
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  left_low,
    input  wire logic [7:0]  left_mid,
    input  wire logic [7:0]  left_high,
    input  wire logic [7:0]  right_low,
    input  wire logic [7:0]  right_mid,
    input  wire logic [7:0]  right_high,
    input  wire logic        ends_column,
    input  wire logic        starts_view,
    // bars
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      column_index,
    output logic [12:0]      red,
    output logic [12:0]      green,
    output logic [12:0]      blue,
    output logic signed [15:0] bar_top,
    output logic signed [15:0] bar_bottom
);

    localparam int LvlW  = wcrp_pkg::LvlW;
    localparam int PgW   = wcrp_pkg::LvlW + wcrp_pkg::GainW;
    localparam int CompW = wcrp_pkg::CompW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL1   = 3'd1;
    localparam logic [2:0] S_MUL2   = 3'd2;
    localparam logic [2:0] S_MAX    = 3'd3;
    localparam logic [2:0] S_NSTART = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;

    // Configuration registers
    logic [15:0] low_gain_reg, mid_gain_reg, high_gain_reg, overall_reg;
    logic [11:0] half_reg;
    logic [23:0] low_clr_reg, mid_clr_reg, high_clr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_gain_reg  <= 16'd4096;
            mid_gain_reg  <= 16'd4096;
            high_gain_reg <= 16'd4096;
            overall_reg   <= 16'd4096;
            half_reg      <= 12'd64;
            low_clr_reg   <= 24'hFF0000;
            mid_clr_reg   <= 24'h00FF00;
            high_clr_reg  <= 24'h0000FF;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                wcrp_pkg::RegLowGain:  low_gain_reg  <= pwdata[15:0];
                wcrp_pkg::RegMidGain:  mid_gain_reg  <= pwdata[15:0];
                wcrp_pkg::RegHighGain: high_gain_reg <= pwdata[15:0];
                wcrp_pkg::RegOverall:  overall_reg   <= pwdata[15:0];
                wcrp_pkg::RegHalf:     half_reg      <= pwdata[11:0];
                wcrp_pkg::RegLowClr:   low_clr_reg   <= pwdata[23:0];
                wcrp_pkg::RegMidClr:   mid_clr_reg   <= pwdata[23:0];
                wcrp_pkg::RegHighClr:  high_clr_reg  <= pwdata[23:0];
                default:               ;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (paddr[4:2])
            wcrp_pkg::RegLowGain:  prdata = {16'b0, low_gain_reg};
            wcrp_pkg::RegMidGain:  prdata = {16'b0, mid_gain_reg};
            wcrp_pkg::RegHighGain: prdata = {16'b0, high_gain_reg};
            wcrp_pkg::RegOverall:  prdata = {16'b0, overall_reg};
            wcrp_pkg::RegHalf:     prdata = {20'b0, half_reg};
            wcrp_pkg::RegLowClr:   prdata = {8'b0, low_clr_reg};
            wcrp_pkg::RegMidClr:   prdata = {8'b0, mid_clr_reg};
            wcrp_pkg::RegHighClr:  prdata = {8'b0, high_clr_reg};
            default:               prdata = '0;
        endcase
    end

    // Front end stage
    logic [2:0]      state_reg, state_next;
    logic            p1_valid_reg, p1_ends_reg, p1_starts_reg;
    logic [LvlW-1:0] p1_ll_reg, p1_lm_reg, p1_lh_reg, p1_rl_reg, p1_rm_reg, p1_rh_reg;
    logic            in_acc;
    logic [wcrp_pkg::EnergyW-1:0] e_left, e_right;

    assign in_stall = (state_reg != S_IDLE) || (p1_valid_reg && p1_ends_reg);
    assign in_acc   = in_valid && !in_stall;

    wcrp_energy u_lane_left
    (
        .clk       (clk),
        .load      (in_acc),
        .lvl_low   (left_low),
        .lvl_mid   (left_mid),
        .lvl_high  (left_high),
        .gain_low  (low_gain_reg),
        .gain_mid  (mid_gain_reg),
        .gain_high (high_gain_reg),
        .energy    (e_left)
    );

    wcrp_energy u_lane_right
    (
        .clk       (clk),
        .load      (in_acc),
        .lvl_low   (right_low),
        .lvl_mid   (right_mid),
        .lvl_high  (right_high),
        .gain_low  (low_gain_reg),
        .gain_mid  (mid_gain_reg),
        .gain_high (high_gain_reg),
        .energy    (e_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= in_acc;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p1_ends_reg   <= ends_column;
            p1_starts_reg <= starts_view;
            p1_ll_reg     <= left_low;
            p1_lm_reg     <= left_mid;
            p1_lh_reg     <= left_high;
            p1_rl_reg     <= right_low;
            p1_rm_reg     <= right_mid;
            p1_rh_reg     <= right_high;
        end
    end

    function automatic logic [LvlW-1:0] max3(input logic [LvlW-1:0] a,
                                             input logic [LvlW-1:0] b,
                                             input logic [LvlW-1:0] c);
        logic [LvlW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Column maxima (merge of the lanes)
    logic [LvlW-1:0] pk_low_reg, pk_mid_reg, pk_high_reg;
    logic [wcrp_pkg::EnergyW-1:0] el_pk_reg, er_pk_reg;
    logic [wcrp_pkg::ColW-1:0]    col_reg;
    logic            finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_low_reg  <= '0;
            pk_mid_reg  <= '0;
            pk_high_reg <= '0;
            el_pk_reg   <= '0;
            er_pk_reg   <= '0;
            col_reg     <= '0;
        end
        else if (finish)
        begin
            pk_low_reg  <= '0;
            pk_mid_reg  <= '0;
            pk_high_reg <= '0;
            el_pk_reg   <= '0;
            er_pk_reg   <= '0;
            if (col_reg == wcrp_pkg::ColW'(wcrp_pkg::MaxColumns - 1))
                col_reg <= '0;
            else
                col_reg <= col_reg + 1'b1;
        end
        else if (p1_valid_reg)
        begin
            pk_low_reg  <= max3(pk_low_reg, p1_ll_reg, p1_rl_reg);
            pk_mid_reg  <= max3(pk_mid_reg, p1_lm_reg, p1_rm_reg);
            pk_high_reg <= max3(pk_high_reg, p1_lh_reg, p1_rh_reg);
            if (e_left > el_pk_reg)
                el_pk_reg <= e_left;
            if (e_right > er_pk_reg)
                er_pk_reg <= e_right;
            if (p1_starts_reg)
                col_reg <= '0;
        end
    end

    // Column-end sequencer
    logic [PgW-1:0]   pg_low_reg, pg_mid_reg, pg_high_reg;
    logic [CompW-1:0] cr_reg, cg_reg, cb_reg, m_reg;
    logic             root_start, norm_start;
    logic             dn_l, dn_r, dn_cr, dn_cg, dn_cb;
    logic [wcrp_pkg::OffW-1:0] off_l, off_r;
    logic [wcrp_pkg::ClrW-1:0] v_r, v_g, v_b;
    logic             out_free;

    assign out_free   = !out_valid || !out_stall;
    assign root_start = (state_reg == S_MUL1);
    assign norm_start = (state_reg == S_NSTART);
    assign finish     = (state_reg == S_WAIT) && dn_l && dn_r && dn_cr && dn_cg && dn_cb
                        && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (p1_valid_reg && p1_ends_reg) state_next = S_MUL1;
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_MAX;
            S_MAX:    state_next = S_NSTART;
            S_NSTART: state_next = S_WAIT;
            S_WAIT:   if (finish) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    function automatic logic [CompW-1:0] mix(input logic [PgW-1:0] a, input logic [7:0] ca,
                                             input logic [PgW-1:0] b, input logic [7:0] cb,
                                             input logic [PgW-1:0] c, input logic [7:0] cc);
        return CompW'(a) * CompW'(ca) + CompW'(b) * CompW'(cb) + CompW'(c) * CompW'(cc);
    endfunction

    // Colour products: peak x gain, then x band colour, then max
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1)
        begin
            pg_low_reg  <= pk_low_reg * low_gain_reg;
            pg_mid_reg  <= pk_mid_reg * mid_gain_reg;
            pg_high_reg <= pk_high_reg * high_gain_reg;
        end
        if (state_reg == S_MUL2)
        begin
            cr_reg <= mix(pg_low_reg, low_clr_reg[23:16], pg_mid_reg, mid_clr_reg[23:16],
                          pg_high_reg, high_clr_reg[23:16]);
            cg_reg <= mix(pg_low_reg, low_clr_reg[15:8], pg_mid_reg, mid_clr_reg[15:8],
                          pg_high_reg, high_clr_reg[15:8]);
            cb_reg <= mix(pg_low_reg, low_clr_reg[7:0], pg_mid_reg, mid_clr_reg[7:0],
                          pg_high_reg, high_clr_reg[7:0]);
        end
        if (state_reg == S_MAX)
        begin
            if (cr_reg >= cg_reg && cr_reg >= cb_reg)
                m_reg <= cr_reg;
            else if (cg_reg >= cb_reg)
                m_reg <= cg_reg;
            else
                m_reg <= cb_reg;
        end
    end

    wcrp_root u_root_left
    (
        .clk (clk), .rst_n (rst_n), .start (root_start), .energy (el_pk_reg),
        .overall_gain (overall_reg), .half_height (half_reg), .done (dn_l), .offset (off_l)
    );

    wcrp_root u_root_right
    (
        .clk (clk), .rst_n (rst_n), .start (root_start), .energy (er_pk_reg),
        .overall_gain (overall_reg), .half_height (half_reg), .done (dn_r), .offset (off_r)
    );

    wcrp_norm u_norm_red
    (
        .clk (clk), .rst_n (rst_n), .start (norm_start), .comp (cr_reg), .maxv (m_reg),
        .done (dn_cr), .value (v_r)
    );

    wcrp_norm u_norm_green
    (
        .clk (clk), .rst_n (rst_n), .start (norm_start), .comp (cg_reg), .maxv (m_reg),
        .done (dn_cg), .value (v_g)
    );

    wcrp_norm u_norm_blue
    (
        .clk (clk), .rst_n (rst_n), .start (norm_start), .comp (cb_reg), .maxv (m_reg),
        .done (dn_cb), .value (v_b)
    );

    // Bar ends with saturation
    logic signed [25:0] top_w, bot_w;
    logic signed [15:0] top_sat, bot_sat;

    assign top_w = $signed({6'b0, half_reg, 4'b0000}) - $signed({2'b0, off_l});
    assign bot_w = $signed({6'b0, half_reg, 4'b0000}) + $signed({2'b0, off_r});

    always_comb
    begin
        if (top_w > 26'sd32767)
            top_sat = 16'sh7FFF;
        else if (top_w < -26'sd32768)
            top_sat = -16'sh8000;
        else
            top_sat = top_w[15:0];
        if (bot_w > 26'sd32767)
            bot_sat = 16'sh7FFF;
        else
            bot_sat = bot_w[15:0];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (finish)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            column_index <= 12'(col_reg);
            red          <= v_r;
            green        <= v_g;
            blue         <= v_b;
            bar_top      <= top_sat;
            bar_bottom   <= bot_sat;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wcrp_energy.sv
// One channel lane of the frame front end: registers squared band levels,
// then weights them by the band gains. Depends on wcrp_pkg.
`default_nettype none

module wcrp_energy
(
    input  wire logic                            clk,
    input  wire logic                            load,
    input  wire logic [wcrp_pkg::LvlW-1:0]       lvl_low,
    input  wire logic [wcrp_pkg::LvlW-1:0]       lvl_mid,
    input  wire logic [wcrp_pkg::LvlW-1:0]       lvl_high,
    input  wire logic [wcrp_pkg::GainW-1:0]      gain_low,
    input  wire logic [wcrp_pkg::GainW-1:0]      gain_mid,
    input  wire logic [wcrp_pkg::GainW-1:0]      gain_high,
    output logic      [wcrp_pkg::EnergyW-1:0]    energy
);

    logic [2*wcrp_pkg::LvlW-1:0] sq_low_reg, sq_mid_reg, sq_high_reg;

    // Square stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sq_low_reg  <= lvl_low * lvl_low;
            sq_mid_reg  <= lvl_mid * lvl_mid;
            sq_high_reg <= lvl_high * lvl_high;
        end
    end

    // Gain weighting
    assign energy = wcrp_pkg::EnergyW'(sq_low_reg)  * wcrp_pkg::EnergyW'(gain_low)
                  + wcrp_pkg::EnergyW'(sq_mid_reg)  * wcrp_pkg::EnergyW'(gain_mid)
                  + wcrp_pkg::EnergyW'(sq_high_reg) * wcrp_pkg::EnergyW'(gain_high);

endmodule

`default_nettype wire

>>> hw/rtl/wcrp_root.sv
// Bar offset lane: finds the largest q with 3*q*q <= energy*65536 one digit a
// cycle (the integer root of energy*65536/3), then scales. Depends on wcrp_pkg.
`default_nettype none

module wcrp_root
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [wcrp_pkg::EnergyW-1:0]    energy,
    input  wire logic [wcrp_pkg::GainW-1:0]      overall_gain,
    input  wire logic [wcrp_pkg::HalfW-1:0]      half_height,
    output logic                                 done,
    output logic      [wcrp_pkg::OffW-1:0]       offset
);

    localparam int ShW   = wcrp_pkg::EnergyW + 16;
    localparam int RootW = ShW / 2;
    // remainder stays below 6*root + 3
    localparam int RemW  = RootW + 3;
    localparam int GhW   = wcrp_pkg::GainW + wcrp_pkg::HalfW;
    localparam int ProdW = GhW + RootW;

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_SQRT = 3'd2;
    localparam logic [2:0] P_MUL  = 3'd3;
    localparam logic [2:0] P_DONE = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [ShW-1:0]   sh_reg, sh_next;
    logic [RemW-1:0]  rem_reg, rem_next;
    logic [RootW-1:0] root_reg, root_next;
    logic [GhW-1:0]   gh_reg, gh_next;
    logic [ProdW-1:0] prod_reg, prod_next;

    logic [RootW+1:0] four1;
    logic [RemW+1:0]  rs, trial;
    logic [ProdW:0]   rounded;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        gh_next    = gh_reg;
        prod_next  = prod_reg;
        rs         = {rem_reg, sh_reg[ShW-1:ShW-2]};
        four1      = {root_reg, 2'b01};
        // trial = 3 * (4*root + 1)
        trial      = (RemW+2)'(four1) + (RemW+2)'({four1, 1'b0});
        unique case (phase_reg)
            P_IDLE, P_DONE:
            begin
                if (start)
                begin
                    phase_next = P_SQRT;
                    cnt_next   = '0;
                    sh_next    = {energy, 16'b0};
                    rem_next   = '0;
                    root_next  = '0;
                    gh_next    = overall_gain * half_height;
                end
            end
            // Root of N/3, one result bit a cycle
            P_SQRT:
            begin
                if (rs >= trial)
                begin
                    rem_next  = RemW'(rs - trial);
                    root_next = {root_reg[RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = RemW'(rs);
                    root_next = {root_reg[RootW-2:0], 1'b0};
                end
                sh_next  = {sh_reg[ShW-3:0], 2'b00};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(RootW - 1))
                    phase_next = P_MUL;
            end
            P_MUL:
            begin
                prod_next  = ProdW'(gh_reg) * ProdW'(root_reg);
                phase_next = P_DONE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        gh_reg   <= gh_next;
        prod_reg <= prod_next;
    end

    // Round at bit 30
    assign rounded = {1'b0, prod_reg} + (ProdW+1)'(1 << 29);
    assign offset  = rounded[30 +: wcrp_pkg::OffW];
    assign done    = (phase_reg == P_DONE);

endmodule

`default_nettype wire

>>> hw/rtl/wcrp_norm.sv
// Colour lane: restoring divider giving (C*4096 + M/2) / M, one quotient
// bit a cycle, black when M is zero. Depends on wcrp_pkg.
`default_nettype none

module wcrp_norm
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [wcrp_pkg::CompW-1:0]      comp,
    input  wire logic [wcrp_pkg::CompW-1:0]      maxv,
    output logic                                 done,
    output logic      [wcrp_pkg::ClrW-1:0]       value
);

    localparam int QW = wcrp_pkg::ClrW;
    localparam int NW = wcrp_pkg::CompW + QW;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_RUN  = 2'd1;
    localparam logic [1:0] P_DONE = 2'd2;

    logic [1:0]                   phase_reg, phase_next;
    logic [3:0]                   cnt_reg, cnt_next;
    logic [wcrp_pkg::CompW-1:0]   r_reg, r_next;
    logic [wcrp_pkg::CompW-1:0]   m_reg, m_next;
    logic [QW-1:0]                low_reg, low_next;
    logic                         mzero_reg, mzero_next;

    logic [wcrp_pkg::CompW:0]     t;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        m_next     = m_reg;
        low_next   = low_reg;
        mzero_next = mzero_reg;
        t          = {r_reg, low_reg[QW-1]};
        unique case (phase_reg)
            P_IDLE, P_DONE:
            begin
                if (start)
                begin
                    // numerator = C*4096 + M/2; quotient fits in 13 bits
                    logic [NW-1:0] n;
                    n          = {1'b0, comp, 12'b0} + NW'(maxv >> 1);
                    r_next     = n[NW-1:QW];
                    low_next   = n[QW-1:0];
                    m_next     = maxv;
                    mzero_next = (maxv == '0);
                    cnt_next   = '0;
                    phase_next = P_RUN;
                end
            end
            P_RUN:
            begin
                if (t >= {1'b0, m_reg})
                begin
                    r_next   = wcrp_pkg::CompW'(t - {1'b0, m_reg});
                    low_next = {low_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    r_next   = t[wcrp_pkg::CompW-1:0];
                    low_next = {low_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(QW - 1))
                    phase_next = P_DONE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        m_reg     <= m_next;
        low_reg   <= low_next;
        mzero_reg <= mzero_next;
    end

    assign done  = (phase_reg == P_DONE);
    assign value = mzero_reg ? '0 : low_reg;

endmodule

`default_nettype wire
